@@ rtl/core/king_connectivity_column_transition_macros.svh @@
// Assertion macros shared by the column transition design.
`ifndef KING_CONNECTIVITY_COLUMN_TRANSITION_MACROS_SVH
`define KING_CONNECTIVITY_COLUMN_TRANSITION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define KCCT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define KCCT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KCCT_ASSERT_IMP(name, ante, cons)
`define KCCT_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ rtl/core/kcct_pkg.sv @@
// Types and constants of the column transition design.
`timescale 1ns / 1ps
`default_nettype none
package kcct_pkg;
    localparam int LABELS = 16;
    localparam int LABEL_W = 4;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LIMIT = 8'd1;
    localparam logic [4:0] ROW_COUNT_RESET = 5'd15;
    localparam logic [7:0] AREA_LIMIT_RESET = 8'd40;
    typedef logic [LABELS-1:0] lset_t;
    typedef lset_t [LABELS-1:0] adj_t;
endpackage
`default_nettype wire

@@ rtl/core/kcct_close_stage.sv @@
// One registered stage of the label closure: squares the reachability matrix twice.
`timescale 1ns / 1ps
`default_nettype none
module kcct_close_stage
    import kcct_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire adj_t adj,
    output adj_t      adj_sq
);
    adj_t mid;
    adj_t fin;
    adj_t adj_reg;
    adj_t adj_next;

    always_comb
    begin
        mid = '0;
        fin = '0;
        for (int i = 0; i < LABELS; i++)
        begin
            for (int j = 0; j < LABELS; j++)
            begin
                mid[i][j] = |(adj[i] & {adj[15][j], adj[14][j], adj[13][j], adj[12][j],
                    adj[11][j], adj[10][j], adj[9][j], adj[8][j], adj[7][j], adj[6][j],
                    adj[5][j], adj[4][j], adj[3][j], adj[2][j], adj[1][j], adj[0][j]});
            end
        end
        for (int i = 0; i < LABELS; i++)
        begin
            for (int j = 0; j < LABELS; j++)
            begin
                fin[i][j] = |(mid[i] & {mid[15][j], mid[14][j], mid[13][j], mid[12][j],
                    mid[11][j], mid[10][j], mid[9][j], mid[8][j], mid[7][j], mid[6][j],
                    mid[5][j], mid[4][j], mid[3][j], mid[2][j], mid[1][j], mid[0][j]});
            end
        end
        adj_next = en ? fin : adj_reg;
    end

    always_ff @(posedge clk)
    begin
        adj_reg <= adj_next;
    end

    assign adj_sq = adj_reg;
endmodule
`default_nettype wire

@@ rtl/core/king_connectivity_column_transition.sv @@
// Throughput: one word per cycle; the six stage pipeline halts as a whole on out_stall while out_valid is high.
// Stages: decode, run merge, two closure stages of two squarings each, grouping, relabel.
// Reset: asynchronous active low; clears the valid bits and sets row_count 15,
// area_limit 40. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "king_connectivity_column_transition_macros.svh"
module king_connectivity_column_transition
    import kcct_pkg::*;
#(
    parameter int MAX_ROWS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [7:0]                cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [4*MAX_ROWS-1:0]     boundary_state,
    input  wire logic [MAX_ROWS-1:0]       column_mask,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           accepted,
    output logic [4*MAX_ROWS-1:0]          next_state,
    output logic [$clog2(MAX_ROWS+1)-1:0]  cells_added,
    output logic                           input_closable
);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ST_W = 4 * MAX_ROWS;

    typedef lset_t [MAX_ROWS-1:0] rowset_t;
    typedef logic [MAX_ROWS-1:0][MAX_ROWS-1:0] rowmat_t;

    logic [4:0] row_count_reg;
    logic [7:0] area_limit_reg;
    logic [5:0] valid_reg;
    logic en;

    // Stage 1 words.
    logic [MAX_ROWS-1:0] s1_mask_reg, s1_mask_next;
    rowset_t s1_touch_reg, s1_touch_next;
    lset_t s1_prev_reg, s1_prev_next;
    logic [CNT_W-1:0] s1_add_reg, s1_add_next;
    // Stage 2 words.
    logic [MAX_ROWS-1:0] s2_mask_reg;
    rowset_t s2_run_reg, s2_run_next;
    adj_t s2_adj_next, s2_adj_reg;
    logic s2_ok_reg, s2_ok_next;
    logic s2_close_reg;
    logic [CNT_W-1:0] s2_add_reg;
    // Stages 3 and 4 side words.
    logic [MAX_ROWS-1:0] s3_mask_reg, s4_mask_reg;
    rowset_t s3_run_reg, s4_run_reg;
    logic s3_ok_reg, s4_ok_reg, s3_close_reg, s4_close_reg;
    logic [CNT_W-1:0] s3_add_reg, s4_add_reg;
    adj_t s3_adj, s4_adj;
    // Stage 5 words.
    rowmat_t s5_rep_reg, s5_rep_next;
    logic [MAX_ROWS-1:0] s5_first_reg, s5_first_next;
    logic s5_ok_reg, s5_close_reg;
    logic [CNT_W-1:0] s5_add_reg;
    // Output words.
    logic [ST_W-1:0] s6_state_reg, s6_state_next;
    logic s6_ok_reg, s6_close_reg;
    logic [CNT_W-1:0] s6_add_reg;

    function automatic logic run_link(logic [MAX_ROWS-1:0] m, int a, int b);
        logic res;
        res = 1'b1;
        for (int k = 0; k < MAX_ROWS; k++)
        begin
            if ((k >= a && k <= b) || (k >= b && k <= a))
            begin
                res = res & m[k];
            end
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign en = !(valid_reg[5] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
            area_limit_reg <= AREA_LIMIT_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROW_COUNT)
                begin
                    row_count_reg <= cfg_data[4:0];
                end
                else if (cfg_index == CFG_AREA_LIMIT)
                begin
                    area_limit_reg <= cfg_data;
                end
            end
            if (en)
            begin
                valid_reg <= {valid_reg[4:0], in_valid};
            end
        end
    end

    // Stage 1: clamp the height, decode labels into one-hot sets, count cells.
    always_comb
    begin
        logic [4:0] hc;
        lset_t oh [MAX_ROWS];
        hc = row_count_reg;
        if (row_count_reg == 5'd0)
        begin
            hc = 5'd1;
        end
        else if (row_count_reg > 5'(MAX_ROWS))
        begin
            hc = 5'(MAX_ROWS);
        end
        s1_prev_next = '0;
        s1_add_next = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            s1_mask_next[r] = column_mask[r] && (5'(r) < hc);
            oh[r] = lset_t'(1) << boundary_state[4*r +: 4];
            oh[r][0] = 1'b0;
            if (!(5'(r) < hc))
            begin
                oh[r] = '0;
            end
            s1_prev_next = s1_prev_next | oh[r];
            s1_add_next = s1_add_next + CNT_W'(s1_mask_next[r]);
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            s1_touch_next[r] = '0;
            if (s1_mask_next[r])
            begin
                s1_touch_next[r] = oh[r];
                if (r > 0)
                begin
                    s1_touch_next[r] = s1_touch_next[r] | oh[r-1];
                end
                if (r < MAX_ROWS - 1)
                begin
                    s1_touch_next[r] = s1_touch_next[r] | oh[r+1];
                end
            end
        end
    end

    // Stage 2: gather labels over each vertical run and build the label adjacency.
    always_comb
    begin
        lset_t touched;
        touched = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            touched = touched | s1_touch_reg[r];
            s2_run_next[r] = '0;
            for (int s = 0; s < MAX_ROWS; s++)
            begin
                if (run_link(s1_mask_reg, s, r))
                begin
                    s2_run_next[r] = s2_run_next[r] | s1_touch_reg[s];
                end
            end
        end
        for (int i = 0; i < LABELS; i++)
        begin
            for (int j = 0; j < LABELS; j++)
            begin
                s2_adj_next[i][j] = (i == j);
                for (int r = 0; r < MAX_ROWS; r++)
                begin
                    s2_adj_next[i][j] = s2_adj_next[i][j]
                        | (s2_run_next[r][i] & s2_run_next[r][j]);
                end
            end
        end
        s2_ok_next = (touched == s1_prev_reg) && (8'(s1_add_reg) < area_limit_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mask_reg <= s1_mask_next;
            s1_touch_reg <= s1_touch_next;
            s1_prev_reg <= s1_prev_next;
            s1_add_reg <= s1_add_next;
            s2_mask_reg <= s1_mask_reg;
            s2_run_reg <= s2_run_next;
            s2_adj_reg <= s2_adj_next;
            s2_ok_reg <= s2_ok_next;
            s2_close_reg <= $onehot(s1_prev_reg);
            s2_add_reg <= s1_add_reg;
            s3_mask_reg <= s2_mask_reg;
            s3_run_reg <= s2_run_reg;
            s3_ok_reg <= s2_ok_reg;
            s3_close_reg <= s2_close_reg;
            s3_add_reg <= s2_add_reg;
            s4_mask_reg <= s3_mask_reg;
            s4_run_reg <= s3_run_reg;
            s4_ok_reg <= s3_ok_reg;
            s4_close_reg <= s3_close_reg;
            s4_add_reg <= s3_add_reg;
            s5_rep_reg <= s5_rep_next;
            s5_first_reg <= s5_first_next;
            s5_ok_reg <= s4_ok_reg;
            s5_close_reg <= s4_close_reg;
            s5_add_reg <= s4_add_reg;
            s6_state_reg <= s6_state_next;
            s6_ok_reg <= s5_ok_reg;
            s6_close_reg <= s5_close_reg;
            s6_add_reg <= s5_add_reg;
        end
    end

    kcct_close_stage u_close_a
    (
        .clk    (clk),
        .en     (en),
        .adj    (s2_adj_reg),
        .adj_sq (s3_adj)
    );

    kcct_close_stage u_close_b
    (
        .clk    (clk),
        .en     (en),
        .adj    (s3_adj),
        .adj_sq (s4_adj)
    );

    // Stage 5: two cells share a component if they share a run or reach the same
    // closed label group. Each cell points at the lowest row of its component.
    always_comb
    begin
        lset_t grp [MAX_ROWS];
        rowmat_t same;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            grp[r] = '0;
            for (int a = 0; a < LABELS; a++)
            begin
                if (s4_run_reg[r][a])
                begin
                    grp[r] = grp[r] | s4_adj[a];
                end
            end
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int s = 0; s < MAX_ROWS; s++)
            begin
                same[r][s] = s4_mask_reg[r] && s4_mask_reg[s]
                    && (run_link(s4_mask_reg, s, r) || ((grp[s] != '0) && (grp[s] == grp[r])));
            end
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int s = 0; s < MAX_ROWS; s++)
            begin
                s5_rep_next[r][s] = same[r][s];
                for (int t = 0; t < MAX_ROWS; t++)
                begin
                    if (t < s && same[r][t])
                    begin
                        s5_rep_next[r][s] = 1'b0;
                    end
                end
            end
            s5_first_next[r] = s5_rep_next[r][r];
        end
    end

    // Stage 6: a component's label is its rank among first-seen rows.
    always_comb
    begin
        logic [CNT_W-1:0] rank [MAX_ROWS];
        logic [LABEL_W-1:0] lab;
        for (int s = 0; s < MAX_ROWS; s++)
        begin
            rank[s] = '0;
            for (int t = 0; t < MAX_ROWS; t++)
            begin
                if (t <= s)
                begin
                    rank[s] = rank[s] + CNT_W'(s5_first_reg[t]);
                end
            end
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            lab = '0;
            for (int s = 0; s < MAX_ROWS; s++)
            begin
                if (s5_rep_reg[r][s])
                begin
                    lab = lab | LABEL_W'(rank[s]);
                end
            end
            s6_state_next[4*r +: 4] = s5_ok_reg ? lab : '0;
        end
    end

    assign out_valid = valid_reg[5];
    assign accepted = s6_ok_reg;
    assign next_state = s6_state_reg;
    assign cells_added = s6_add_reg;
    assign input_closable = s6_close_reg;

    `KCCT_ASSERT_IMP(a_reject_clear, out_valid && !accepted, next_state == '0)
    `KCCT_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
    `KCCT_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire
